[design/adcrs_pkg.sv]
// ============================================================================
// adcrs_pkg
// Shared types and constants for the ADC channel request sequencer.
// ============================================================================
package adcrs_pkg;

    localparam int NUM_CHANNELS = 7;
    localparam int REF_CHANNEL  = 6;

    // Widths of the transfer fields.
    localparam int CH_W     = 3;
    localparam int SAMPLE_W = 16;
    localparam int RES_W    = 2;
    localparam int OVS_W    = 4;
    localparam int RATIO_W  = 3;

    // Configuration registers.
    localparam int RES_REG_W = RES_W * NUM_CHANNELS;
    localparam int OVS_REG_W = OVS_W * NUM_CHANNELS;
    localparam int NUM_REGS  = 2;
    localparam int PDATA_W   = 32;
    localparam int PADDR_W   = $clog2(4 * NUM_REGS);
    localparam int REG_IDX_W = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_RESOLUTION   = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_OVERSAMPLING = REG_IDX_W'(1);

    localparam logic [RES_REG_W-1:0] RES_RESET = '0;
    localparam logic [OVS_REG_W-1:0] OVS_RESET =
        OVS_REG_W'(OVS_REG_W'(8) << (OVS_W * REF_CHANNEL));

    // Largest oversampling code; larger codes saturate.
    localparam logic [OVS_W-1:0] OVS_MAX = OVS_W'(8);

    // Input operation codes.
    localparam logic OP_REQUEST  = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // Result kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // Resolution codes.
    localparam logic [RES_W-1:0] RES_12B = 2'd0;
    localparam logic [RES_W-1:0] RES_10B = 2'd1;
    localparam logic [RES_W-1:0] RES_8B  = 2'd2;
    localparam logic [RES_W-1:0] RES_6B  = 2'd3;

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef struct packed {
        logic [RES_REG_W-1:0] res_codes;
        logic [OVS_REG_W-1:0] ovs_codes;
    } t_cfg;

    typedef struct packed {
        logic                kind;
        logic [CH_W-1:0]     channel_res;
        logic [RES_W-1:0]    resolution_code;
        logic                ovs_enable;
        logic [RATIO_W-1:0]  ovs_ratio;
        logic [OVS_W-1:0]    ovs_shift;
        logic [SAMPLE_W-1:0] value;
        logic [SAMPLE_W-1:0] ref_reading;
        logic                last;
    } t_result;

    // Up to two results pushed into the queue per item.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

[design/adcrs_regs.sv]
// ============================================================================
// adcrs_regs
// APB register file: per-channel resolution and oversampling codes.
// ============================================================================
module adcrs_regs import adcrs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic [RES_REG_W-1:0] r_res;
    logic [OVS_REG_W-1:0] r_ovs;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= RES_RESET;
            r_ovs <= OVS_RESET;
        end else if (wr_en) begin
            unique case (idx)
                REG_RESOLUTION:   r_res <= pwdata[RES_REG_W-1:0];
                REG_OVERSAMPLING: r_ovs <= pwdata[OVS_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_RESOLUTION:   prdata = PDATA_W'(r_res);
            REG_OVERSAMPLING: prdata = PDATA_W'(r_ovs);
            default:          prdata = '0;
        endcase
    end

    assign o_cfg.res_codes = r_res;
    assign o_cfg.ovs_codes = r_ovs;

endmodule

[design/adcrs_core.sv]
// ============================================================================
// adcrs_core
// Input stage register, sequencer state and one-pass result generation.
// ============================================================================
module adcrs_core import adcrs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_op,
    input  logic [CH_W-1:0]     i_channel,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_room,
    output t_push               o_push
);

    // Start command for a channel with its resolution and oversampling.
    function automatic t_result start_cmd(input logic [CH_W-1:0] ch, input t_cfg cfg);
        t_result          r;
        logic [OVS_W-1:0] k;
        k = cfg.ovs_codes[OVS_W*ch +: OVS_W];
        if (k > OVS_MAX) k = OVS_MAX;
        r                 = '0;
        r.kind            = KIND_START;
        r.channel_res     = ch;
        r.resolution_code = cfg.res_codes[RES_W*ch +: RES_W];
        r.ovs_enable      = (k != '0);
        r.ovs_ratio       = (k != '0) ? RATIO_W'(k - OVS_W'(1)) : '0;
        r.ovs_shift       = k;
        r.last            = 1'b1;
        return r;
    endfunction

    // Input stage
    logic                r_stg_valid;
    logic                r_stg_op;
    logic [CH_W-1:0]     r_stg_ch;
    logic [SAMPLE_W-1:0] r_stg_sample;

    // Sequencer state
    logic [NUM_CHANNELS-1:0] r_pending, n_pending;
    logic                    r_busy, n_busy;
    logic [CH_W-1:0]         r_active, n_active;
    logic                    r_meas, n_meas;
    logic [SAMPLE_W-1:0]     r_ref, n_ref;

    logic fire;

    assign fire       = r_stg_valid && i_room;
    assign o_in_ready = !r_stg_valid || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_stg_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_stg_op     <= i_op;
            r_stg_ch     <= i_channel;
            r_stg_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_busy    <= 1'b0;
            r_active  <= '0;
            r_meas    <= 1'b0;
            r_ref     <= '0;
        end else begin
            r_pending <= n_pending;
            r_busy    <= n_busy;
            r_active  <= n_active;
            r_meas    <= n_meas;
            r_ref     <= n_ref;
        end
    end

    always_comb begin
        logic [CH_W:0]   sum;
        logic [CH_W-1:0] next_ch;
        logic            found;
        t_result         done;

        n_pending = r_pending;
        n_busy    = r_busy;
        n_active  = r_active;
        n_meas    = r_meas;
        n_ref     = r_ref;
        o_push    = '0;
        found     = 1'b0;
        next_ch   = '0;
        done      = '0;

        // Round-robin pick: first pending channel after the active one,
        // the active channel itself checked last.
        for (int i = NUM_CHANNELS; i >= 1; i--) begin
            sum = (CH_W+1)'(r_active) + (CH_W+1)'(i);
            if (sum >= (CH_W+1)'(NUM_CHANNELS)) sum = sum - (CH_W+1)'(NUM_CHANNELS);
            if (r_pending[sum[CH_W-1:0]]) begin
                found   = 1'b1;
                next_ch = sum[CH_W-1:0];
            end
        end

        // Left-aligned sample, truncated to 16 bits.
        done.kind        = KIND_DONE;
        done.channel_res = r_active;
        done.ref_reading = r_ref;
        done.last        = !found;
        case (i_cfg.res_codes[RES_W*r_active +: RES_W])
            RES_12B: done.value = r_stg_sample << 4;
            RES_10B: done.value = r_stg_sample << 6;
            RES_8B:  done.value = r_stg_sample << 8;
            default: done.value = r_stg_sample << 10;
        endcase

        if (fire) begin
            if (r_stg_op == OP_REQUEST) begin
                if (int'(r_stg_ch) < NUM_CHANNELS) begin
                    if (r_busy) begin
                        n_pending[r_stg_ch] = 1'b1;
                    end else begin
                        n_busy              = 1'b1;
                        n_active            = r_stg_ch;
                        n_pending[r_stg_ch] = 1'b0;
                        n_meas              = 1'b0;
                        o_push.cnt          = 2'd1;
                        o_push.r0           = start_cmd(CH_W'(REF_CHANNEL), i_cfg);
                    end
                end
            end else if (r_busy) begin
                if (!r_meas) begin
                    n_ref      = r_stg_sample;
                    n_meas     = 1'b1;
                    o_push.cnt = 2'd1;
                    o_push.r0  = start_cmd(r_active, i_cfg);
                end else begin
                    n_busy     = 1'b0;
                    o_push.cnt = 2'd1;
                    o_push.r0  = done;
                    if (found) begin
                        n_busy             = 1'b1;
                        n_active           = next_ch;
                        n_pending[next_ch] = 1'b0;
                        n_meas             = 1'b0;
                        o_push.cnt         = 2'd2;
                        o_push.r1          = start_cmd(CH_W'(REF_CHANNEL), i_cfg);
                    end
                end
            end
        end
    end

endmodule

[design/adcrs_result_fifo.sv]
// ============================================================================
// adcrs_result_fifo
// Small result queue: up to two pushes per cycle, one pop per cycle.
// ============================================================================
module adcrs_result_fifo import adcrs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt;
    logic                  pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    // Room for a two-result item, ignoring a pop in the same cycle.
    assign o_room  = (r_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) r_mem[r_wr] <= i_push.r0;
        if (i_push.cnt == 2'd2) r_mem[r_wr + FIFO_PTR_W'(1)] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_PTR_W'(i_push.cnt);
            r_rd  <= r_rd + FIFO_PTR_W'(pop);
            r_cnt <= r_cnt + FIFO_CNT_W'(i_push.cnt) - FIFO_CNT_W'(pop);
        end
    end

endmodule

[design/adc_channel_request_sequencer.sv]
// ============================================================================
// adc_channel_request_sequencer
// Round-robin ADC conversion sequencer over the converter channels.
// ============================================================================
//
//  Channel   Direction  Handshake                   Payload
//  --------  ---------  --------------------------  ------------------------------
//  in        sink       i_in_valid / o_in_ready     i_op, i_channel, i_sample
//  out       source     o_out_valid / i_out_ready   o_kind ... o_last
//  apb       slave      psel, penable, pready       paddr, pwdata, prdata
//
//  Path: an accepted transfer is registered in the input stage, is
//  processed there in one pass, and its one or two results are written
//  into the result queue; the oldest result there is driven on the outputs.
//  Rate: one item per cycle, set by the single-pass input stage; the stage
//  stalls only while the four-entry result queue holds more than two results.
//  Reset: synchronous, active low; pending mask, busy flag, phase and queue
//  clear, and the registers return to their reset codes.
//  Stalls: a stalled output keeps its result; new items are still taken
//  while the queue has room for a full two-result item.
//
//  Flow per request: reference-channel start command, then on its
//  completion a start command for the channel, then on that completion a
//  done event with the left-aligned sample, followed by a reference start
//  for the next pending channel in round-robin order.
// ============================================================================
module adc_channel_request_sequencer import adcrs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // request / completion transfers
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_op,
    input  logic [CH_W-1:0]     i_channel,
    input  logic [SAMPLE_W-1:0] i_sample,

    // command / event transfers
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_kind,
    output logic [CH_W-1:0]     o_channel_res,
    output logic [RES_W-1:0]    o_resolution_code,
    output logic                o_ovs_enable,
    output logic [RATIO_W-1:0]  o_ovs_ratio,
    output logic [OVS_W-1:0]    o_ovs_shift,
    output logic [SAMPLE_W-1:0] o_value,
    output logic [SAMPLE_W-1:0] o_ref_reading,
    output logic                o_last,

    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    t_cfg    cfg;
    t_push   push;
    logic    room;
    t_result res;

    // Resolution and oversampling code registers
    adcrs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input stage and sequencer state
    adcrs_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_channel  (i_channel),
        .i_sample   (i_sample),
        .i_room     (room),
        .o_push     (push)
    );

    // Result queue, decouples output stalls from the input side
    adcrs_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (res)
    );

    assign o_kind            = res.kind;
    assign o_channel_res     = res.channel_res;
    assign o_resolution_code = res.resolution_code;
    assign o_ovs_enable      = res.ovs_enable;
    assign o_ovs_ratio       = res.ovs_ratio;
    assign o_ovs_shift       = res.ovs_shift;
    assign o_value           = res.value;
    assign o_ref_reading     = res.ref_reading;
    assign o_last            = res.last;

endmodule

[design/adcrs_checker.sv]
// ============================================================================
// adcrs_checker
// Port-level checks for the ADC channel request sequencer.
// ============================================================================
module adcrs_checker import adcrs_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic                o_kind,
    input logic [RES_W-1:0]    o_resolution_code,
    input logic                o_ovs_enable,
    input logic [RATIO_W-1:0]  o_ovs_ratio,
    input logic [OVS_W-1:0]    o_ovs_shift,
    input logic [SAMPLE_W-1:0] o_value,
    input logic [SAMPLE_W-1:0] o_ref_reading,
    input logic                o_last
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_value) && $stable(o_last))
        else $error("result changed while stalled");

    a_done_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_DONE |-> o_resolution_code == '0
            && !o_ovs_enable && o_ovs_ratio == '0 && o_ovs_shift == '0)
        else $error("done event carries conversion settings");

    a_start_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_START |-> o_value == '0
            && o_ref_reading == '0 && o_last)
        else $error("start command malformed");

    a_ovs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_START |-> o_ovs_shift <= OVS_MAX
            && (o_ovs_enable == (o_ovs_shift != '0))
            && (o_ovs_enable || o_ovs_ratio == '0))
        else $error("oversampling fields inconsistent");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind adc_channel_request_sequencer adcrs_checker u_adcrs_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_kind            (o_kind),
    .o_resolution_code (o_resolution_code),
    .o_ovs_enable      (o_ovs_enable),
    .o_ovs_ratio       (o_ovs_ratio),
    .o_ovs_shift       (o_ovs_shift),
    .o_value           (o_value),
    .o_ref_reading     (o_ref_reading),
    .o_last            (o_last)
);

[tb/adc_channel_request_sequencer_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// adc_channel_request_sequencer_tb
// Self-checking bench for the round-robin ADC conversion sequencer.
//
// Requests and conversion completions go in over a valid/ready channel.
// A cycle-free predictor tracks the pending mask, the busy flag, the active
// channel and the measurement phase, and queues the start commands and done
// events that each accepted transfer should cause. A monitor compares every
// result transfer against the oldest queued one. The run covers a directed
// walk through the pending and scan corner cases, saturated oversampling
// codes, several register settings with random traffic under changing idle
// patterns, and a long output stall that fills the result queue.
// ============================================================================
module adc_channel_request_sequencer_tb;
    import adcrs_pkg::*;

    localparam int SETTLE_CYC   = 8;     // lets the input stage and result queue empty
    localparam int DRAIN_LIMIT  = 5000;  // cycles to wait for queued results
    localparam int HOLD_CYC     = 400;   // long output stall
    localparam int PHASE_ITEMS  = 215;   // counted transfers per setting
    localparam int NUM_PHASES   = 6;

    // ------------------------------------------------------------------------
    // DUT ports
    // ------------------------------------------------------------------------
    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_op;
    logic [CH_W-1:0]     i_channel;
    logic [SAMPLE_W-1:0] i_sample;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_kind;
    logic [CH_W-1:0]     o_channel_res;
    logic [RES_W-1:0]    o_resolution_code;
    logic                o_ovs_enable;
    logic [RATIO_W-1:0]  o_ovs_ratio;
    logic [OVS_W-1:0]    o_ovs_shift;
    logic [SAMPLE_W-1:0] o_value;
    logic [SAMPLE_W-1:0] o_ref_reading;
    logic                o_last;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    adc_channel_request_sequencer dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_op              (i_op),
        .i_channel         (i_channel),
        .i_sample          (i_sample),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_channel_res     (o_channel_res),
        .o_resolution_code (o_resolution_code),
        .o_ovs_enable      (o_ovs_enable),
        .o_ovs_ratio       (o_ovs_ratio),
        .o_ovs_shift       (o_ovs_shift),
        .o_value           (o_value),
        .o_ref_reading     (o_ref_reading),
        .o_last            (o_last),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor state: a copy of the sequencer and of its two registers
    // ------------------------------------------------------------------------
    logic [RES_REG_W-1:0]    cfg_res;
    logic [OVS_REG_W-1:0]    cfg_ovs;
    logic [NUM_CHANNELS-1:0] seq_pending;
    logic                    seq_busy;
    int unsigned             seq_active;
    logic                    seq_in_phase;   // 0: reference conversion running
    logic [SAMPLE_W-1:0]     seq_ref_sample;

    t_result cmd_event_q[$];   // start commands and done events still owed

    int err_cnt         = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int settings_used   = 0;
    int snd_idle_pct    = 0;
    int rcv_idle_pct    = 0;
    int hold_left       = 0;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [RES_W-1:0] res_code_of(input int unsigned c);
        return cfg_res[RES_W*c +: RES_W];
    endfunction

    // codes above the maximum saturate
    function automatic logic [OVS_W-1:0] ovs_code_of(input int unsigned c);
        logic [OVS_W-1:0] k;
        k = cfg_ovs[OVS_W*c +: OVS_W];
        return (k > OVS_MAX) ? OVS_MAX : k;
    endfunction

    function automatic t_result start_cmd(input int unsigned c, input logic is_last);
        t_result          r;
        logic [OVS_W-1:0] k;
        k = ovs_code_of(c);
        r = '0;
        r.kind            = KIND_START;
        r.channel_res     = CH_W'(c);
        r.resolution_code = res_code_of(c);
        r.ovs_enable      = (k != '0);
        r.ovs_ratio       = (k != '0) ? RATIO_W'(k - 1'b1) : '0;
        r.ovs_shift       = k;
        r.last            = is_last;
        return r;
    endfunction

    // left alignment, upper bits fall off
    function automatic logic [SAMPLE_W-1:0] left_align(input logic [SAMPLE_W-1:0] s,
                                                       input logic [RES_W-1:0] rc);
        case (rc)
            RES_12B: return s << 4;
            RES_10B: return s << 6;
            RES_8B:  return s << 8;
            default: return s << 10;
        endcase
    endfunction

    task automatic launch(input int unsigned c);
        seq_busy     = 1'b1;
        seq_active   = c;
        seq_pending[c] = 1'b0;
        seq_in_phase = 1'b0;
    endtask

    task automatic advance_sequencer(input logic op, input logic [CH_W-1:0] ch,
                                     input logic [SAMPLE_W-1:0] s);
        t_result     done;
        int unsigned c;
        logic        found;
        if (op == OP_REQUEST) begin
            if (ch >= NUM_CHANNELS)
                return;
            if (seq_busy) begin
                seq_pending[ch] = 1'b1;
                return;
            end
            launch(ch);
            cmd_event_q.push_back(start_cmd(REF_CHANNEL, 1'b1));
            return;
        end
        if (!seq_busy)
            return;
        if (!seq_in_phase) begin
            seq_ref_sample = s;
            seq_in_phase   = 1'b1;
            cmd_event_q.push_back(start_cmd(seq_active, 1'b1));
            return;
        end
        done = '0;
        done.kind        = KIND_DONE;
        done.channel_res = CH_W'(seq_active);
        done.value       = left_align(s, res_code_of(seq_active));
        done.ref_reading = seq_ref_sample;
        done.last        = 1'b1;
        seq_busy = 1'b0;
        // scan starts after the finished channel and reaches it last
        found = 1'b0;
        c     = 0;
        for (int i = 1; i <= NUM_CHANNELS && !found; i++) begin
            c = (seq_active + i) % NUM_CHANNELS;
            if (seq_pending[c])
                found = 1'b1;
        end
        if (found) begin
            done.last = 1'b0;
            cmd_event_q.push_back(done);
            launch(c);
            cmd_event_q.push_back(start_cmd(REF_CHANNEL, 1'b1));
        end else begin
            cmd_event_q.push_back(done);
        end
    endtask

    // ------------------------------------------------------------------------
    // Reporting and the result monitor
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("result %0d field %s: got 0x%0h, want 0x%0h",
                                      results_checked, name, got, want));
    endtask

    // Outputs are read at the edge, before the DUT's own updates land.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cmd_event_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result: kind %0d channel %0d",
                                          o_kind, o_channel_res));
            end else begin
                want = cmd_event_q.pop_front();
                check_field("kind",            o_kind,            want.kind);
                check_field("channel_res",     o_channel_res,     want.channel_res);
                check_field("resolution_code", o_resolution_code, want.resolution_code);
                check_field("ovs_enable",      o_ovs_enable,      want.ovs_enable);
                check_field("ovs_ratio",       o_ovs_ratio,       want.ovs_ratio);
                check_field("ovs_shift",       o_ovs_shift,       want.ovs_shift);
                check_field("value",           o_value,           want.value);
                check_field("ref_reading",     o_ref_reading,     want.ref_reading);
                check_field("last",            o_last,            want.last);
                results_checked++;
            end
        end
    end

    // Result side: random stalls, or a counted hold-off when one is armed.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // One input transfer. Valid is left high on return; the next call either
    // replaces the payload or drops valid in the same step.
    task automatic offer_transfer(input logic op, input logic [CH_W-1:0] ch,
                                  input logic [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_channel  <= ch;
        i_sample   <= s;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        advance_sequencer(op, ch, s);
        items_sent++;
    endtask

    // APB register write with setup and access phases; the predictor copy follows at the access edge.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_RESOLUTION)
            cfg_res = data[RES_REG_W-1:0];
        else
            cfg_ovs = data[OVS_REG_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering, wait for every owed result, then let the pipe empty.
    task automatic settle();
        int w;
        i_in_valid <= 1'b0;
        w = 0;
        while (cmd_event_q.size() != 0 && w < DRAIN_LIMIT) begin
            @(posedge i_clk);
            w++;
        end
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (cmd_event_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", cmd_event_q.size()));
            cmd_event_q.delete();
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return '1;
        return SAMPLE_W'($urandom);
    endfunction

    // Mostly well-formed traffic: requests while idle, completions while busy,
    // extra requests piling up in the pending mask; some ignored noise.
    // Only transfers the block acts on count toward n.
    task automatic random_traffic(input int n);
        int                  counted;
        int                  roll;
        logic                op;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] s;
        counted = 0;
        while (counted < n) begin
            roll = $urandom_range(99);
            s    = random_sample();
            if (seq_busy) begin
                if (roll < 60) begin
                    op = OP_COMPLETE;
                    ch = CH_W'($urandom);
                end else if (roll < 93) begin
                    op = OP_REQUEST;
                    ch = CH_W'($urandom_range(NUM_CHANNELS - 1));
                end else begin
                    op = OP_REQUEST;
                    ch = '1;
                end
            end else begin
                if (roll < 85) begin
                    op = OP_REQUEST;
                    ch = CH_W'($urandom_range(NUM_CHANNELS - 1));
                end else if (roll < 93) begin
                    op = OP_COMPLETE;
                    ch = CH_W'($urandom);
                end else begin
                    op = OP_REQUEST;
                    ch = '1;
                end
            end
            if (!(op == OP_REQUEST && ch >= NUM_CHANNELS) && !(op == OP_COMPLETE && !seq_busy))
                counted++;
            offer_transfer(op, ch, s);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset settings: 12-bit everywhere, reference oversampled at the maximum.
    task automatic test_directed_sequence();
        offer_transfer(OP_REQUEST,  3'd0, 16'h0000);  // idle: reference start
        offer_transfer(OP_COMPLETE, 3'd0, 16'h1234);  // reference done: ch0 start
        offer_transfer(OP_REQUEST,  3'd0, 16'h0000);  // active channel goes pending
        offer_transfer(OP_REQUEST,  3'd3, 16'h0000);  // pending
        offer_transfer(OP_REQUEST,  3'd7, 16'hFFFF);  // no such channel
        offer_transfer(OP_COMPLETE, 3'd7, 16'hFFFF);  // done ch0, ch3 next in scan
        offer_transfer(OP_COMPLETE, 3'd0, 16'h0000);
        offer_transfer(OP_COMPLETE, 3'd0, 16'h8001);  // done ch3, wraps to ch0
        offer_transfer(OP_COMPLETE, 3'd0, 16'hFFFF);
        offer_transfer(OP_COMPLETE, 3'd0, 16'hA5A5);  // done ch0, nothing pending
        offer_transfer(OP_COMPLETE, 3'd5, 16'h5A5A);  // completion while idle
        offer_transfer(OP_REQUEST,  3'd6, 16'h0000);  // the reference channel itself
        offer_transfer(OP_REQUEST,  3'd6, 16'h0000);  // finished channel pending too
        offer_transfer(OP_REQUEST,  3'd5, 16'h0000);
        offer_transfer(OP_COMPLETE, 3'd0, 16'h0000);
        offer_transfer(OP_COMPLETE, 3'd0, 16'hFFFF);  // done ch6: ch5 before ch6
        offer_transfer(OP_COMPLETE, 3'd0, 16'hFFFF);
        offer_transfer(OP_COMPLETE, 3'd0, 16'h0F0F);  // done ch5: finished-last ch6
        offer_transfer(OP_COMPLETE, 3'd0, 16'h7FFF);
        offer_transfer(OP_COMPLETE, 3'd0, 16'h0001);
        settle();
    endtask

    // Codes 9..15 saturate to 8; every resolution shows up.
    task automatic test_oversampling_saturation();
        write_reg(REG_OVERSAMPLING, 32'h0FED_CBA9);
        write_reg(REG_RESOLUTION,   32'(14'b11_10_01_00_11_10_01));
        settings_used++;
        offer_transfer(OP_REQUEST,  3'd2, 16'h0000);
        offer_transfer(OP_COMPLETE, 3'd0, 16'hC3C3);
        offer_transfer(OP_COMPLETE, 3'd0, 16'hFFFF);  // 6-bit: shift by 10
        offer_transfer(OP_REQUEST,  3'd1, 16'h0000);
        offer_transfer(OP_COMPLETE, 3'd0, 16'h0000);
        offer_transfer(OP_COMPLETE, 3'd0, 16'h00FF);  // 8-bit: shift by 8
        settle();
    endtask

    // Extremes first, then random settings; idle pattern changes every two.
    task automatic test_random_settings();
        logic [PDATA_W-1:0] res_val;
        logic [PDATA_W-1:0] ovs_val;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 2) begin
                snd_idle_pct = 19;
                rcv_idle_pct = 48;
            end else if (ph < 4) begin
                snd_idle_pct = 48;
                rcv_idle_pct = 19;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            case (ph)
                0: begin
                    res_val = PDATA_W'({RES_REG_W{1'b1}});
                    ovs_val = PDATA_W'({OVS_REG_W{1'b1}});
                end
                1: begin
                    res_val = '0;
                    ovs_val = '0;
                end
                default: begin
                    res_val = PDATA_W'(RES_REG_W'($urandom));
                    ovs_val = PDATA_W'(OVS_REG_W'($urandom));
                end
            endcase
            write_reg(REG_RESOLUTION, res_val);
            write_reg(REG_OVERSAMPLING, ovs_val);
            settings_used++;
            random_traffic(PHASE_ITEMS);
            settle();
        end
    endtask

    // Output held off for a long stretch while input keeps coming: the
    // result queue fills and the input side must stall, then drain in order.
    task automatic test_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_left <= HOLD_CYC;
        random_traffic(40);
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_op       <= OP_REQUEST;
        i_channel  <= '0;
        i_sample   <= '0;
        i_out_ready <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;

        cfg_res        = RES_RESET;
        cfg_ovs        = OVS_RESET;
        seq_pending    = '0;
        seq_busy       = 1'b0;
        seq_active     = 0;
        seq_in_phase   = 1'b0;
        seq_ref_sample = '0;
        settings_used  = 1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);

        snd_idle_pct = 19;
        rcv_idle_pct = 48;
        test_directed_sequence();
        test_oversampling_saturation();
        test_random_settings();
        test_backpressure();

        $display("Ran %0d input transfers and checked %0d commands/events",
                 items_sent, results_checked);
        $display("over %0d register settings, including saturated codes and a long stall.",
                 settings_used);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[sim.f]
design/adcrs_pkg.sv
design/adcrs_regs.sv
design/adcrs_core.sv
design/adcrs_result_fifo.sv
design/adc_channel_request_sequencer.sv
design/adcrs_checker.sv
tb/adc_channel_request_sequencer_tb.sv
